/* rtl/core/chained_hash_table_top_defines.svh */
// Assertion macros used by the hash table top level.
`ifndef CHAINED_HASH_TABLE_TOP_DEFINES_SVH
`define CHAINED_HASH_TABLE_TOP_DEFINES_SVH

// Immediate-consequence check: when a holds, b holds in the same cycle.
`define CHT_ASSERT_IMPL(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// Next-cycle check: when a holds, b holds in the cycle after.
`define CHT_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

/* rtl/core/cht_pkg.sv */
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types and constants of the chained hash table.
// ----------------------------------------------------------------------------
package cht_pkg;

    localparam int BUCKETS  = 16;
    localparam int POOL     = 64;
    localparam int KEY_BITS = 31;

    localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NODE_W = $clog2(POOL + 1);          // holds POOL as null mark
    localparam int IDX_W  = (POOL > 1) ? $clog2(POOL) : 1;
    localparam int SIZE_W = 5;
    localparam int PROBE_W = 7;

    localparam logic [NODE_W-1:0] NIL = NODE_W'(POOL);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FIND   = 1'b1;

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = SIZE_W'(10);

    // Work item passed from the front (hash) to the back (chain walk).
    typedef struct packed {
        logic                op;
        logic [KEY_BITS-1:0] key;
        logic [BKT_W-1:0]    bucket;
    } t_job;

    typedef struct packed {
        logic               status;
        logic               found;
        logic [PROBE_W-1:0] probes;
    } t_result;

endpackage

/* rtl/core/cht_ram.sv */
// ----------------------------------------------------------------------------
// cht_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/cht_front.sv */
// ----------------------------------------------------------------------------
// cht_front
// Accepts items, reduces the key modulo the table size one bit per cycle,
// and hands the bucketed job to a two-entry queue.
// ----------------------------------------------------------------------------
module cht_front import cht_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic                i_op,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [SIZE_W-1:0]   i_table_size,
    output logic                o_job_valid,
    output t_job                o_job,
    input  logic                i_job_take
);

    typedef enum logic [1:0] {ST_IDLE, ST_MOD, ST_PUSH} t_state;

    t_state              r_state;
    logic [KEY_BITS-1:0] r_key;
    logic                r_op;
    logic [KEY_BITS-1:0] r_shift;
    logic [SIZE_W-1:0]   r_rem;
    logic [SIZE_W-1:0]   r_mod;
    logic [$clog2(KEY_BITS+1)-1:0] r_cnt;

    // Two-entry job queue.
    t_job r_q [2];
    logic r_q_wp, r_q_rp;
    logic [1:0] r_q_cnt;

    logic [SIZE_W-1:0] w_mod;
    logic [SIZE_W:0]   w_trial;
    logic              w_enq;
    logic              w_deq;

    always_comb begin
        w_mod = i_table_size;
        if (w_mod == '0) begin
            w_mod = SIZE_W'(1);
        end else if (w_mod > SIZE_W'(BUCKETS)) begin
            w_mod = SIZE_W'(BUCKETS);
        end
    end

    // Restoring remainder step: shift in the next key bit, subtract if possible.
    assign w_trial = {r_rem, r_shift[KEY_BITS-1]};

    assign o_full = (r_state != ST_IDLE);
    assign w_enq  = (r_state == ST_PUSH) && (r_q_cnt != 2'd2);
    assign w_deq  = i_job_take && (r_q_cnt != 2'd0);
    assign o_job_valid = (r_q_cnt != 2'd0);
    assign o_job       = r_q[r_q_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_q_wp  <= 1'b0;
            r_q_rp  <= 1'b0;
            r_q_cnt <= 2'd0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_push) begin
                        r_op    <= i_op;
                        r_key   <= i_key;
                        r_shift <= i_key;
                        r_rem   <= '0;
                        r_mod   <= w_mod;
                        r_cnt   <= '0;
                        r_state <= ST_MOD;
                    end
                end
                ST_MOD: begin
                    if (w_trial >= {1'b0, r_mod}) begin
                        r_rem <= SIZE_W'(w_trial - {1'b0, r_mod});
                    end else begin
                        r_rem <= SIZE_W'(w_trial);
                    end
                    r_shift <= r_shift << 1;
                    r_cnt   <= r_cnt + 1'b1;
                    if (r_cnt == ($clog2(KEY_BITS+1))'(KEY_BITS - 1)) begin
                        r_state <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (w_enq) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (w_enq) begin
                r_q[r_q_wp] <= '{op: r_op, key: r_key, bucket: BKT_W'(r_rem)};
                r_q_wp <= ~r_q_wp;
            end
            if (w_deq) begin
                r_q_rp <= ~r_q_rp;
            end
            r_q_cnt <= r_q_cnt + {1'b0, w_enq} - {1'b0, w_deq};
        end
    end

endmodule

/* rtl/core/cht_back.sv */
// ----------------------------------------------------------------------------
// cht_back
// Walks bucket chains in the node memories, one node read per cycle, and
// produces one result per job into a two-entry output queue.
// ----------------------------------------------------------------------------
module cht_back import cht_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  t_job               i_job,
    output logic               o_job_take,
    output logic               o_empty,
    input  logic               i_pop,
    output t_result            o_result
);

    typedef enum logic [2:0] {ST_IDLE, ST_START, ST_WAIT, ST_STEP, ST_DONE} t_state;

    t_state             r_state;
    t_job               r_job;
    logic [NODE_W-1:0]  r_head [BUCKETS];
    logic [NODE_W-1:0]  r_used;
    logic [NODE_W-1:0]  r_cur;
    logic [PROBE_W-1:0] r_steps;
    t_result            r_res;

    t_result r_oq [2];
    logic    r_oq_wp, r_oq_rp;
    logic [1:0] r_oq_cnt;

    logic                n_key_we, n_next_we;
    logic [IDX_W-1:0]    n_key_wa, n_next_wa, n_raddr;
    logic [NODE_W-1:0]   n_next_wd;
    logic [KEY_BITS-1:0] w_rkey;
    logic [NODE_W-1:0]   w_rnext;
    logic                w_enq, w_deq;

    cht_ram #(.WIDTH(KEY_BITS), .DEPTH(POOL)) u_key_ram (
        .i_clk  (i_clk),
        .i_we   (n_key_we),
        .i_waddr(n_key_wa),
        .i_wdata(r_job.key),
        .i_raddr(n_raddr),
        .o_rdata(w_rkey)
    );

    cht_ram #(.WIDTH(NODE_W), .DEPTH(POOL)) u_next_ram (
        .i_clk  (i_clk),
        .i_we   (n_next_we),
        .i_waddr(n_next_wa),
        .i_wdata(n_next_wd),
        .i_raddr(n_raddr),
        .o_rdata(w_rnext)
    );

    assign o_job_take = (r_state == ST_IDLE) && i_job_valid;
    assign w_enq = (r_state == ST_DONE) && (r_oq_cnt != 2'd2);
    assign w_deq = i_pop && (r_oq_cnt != 2'd0);
    assign o_empty  = (r_oq_cnt == 2'd0);
    assign o_result = r_oq[r_oq_rp];

    // Memory control: an insert with a free node writes it at ST_START and, on a
    // non-empty chain, links it to the tail in ST_STEP; the read address follows the walk.
    always_comb begin
        n_key_we  = 1'b0;
        n_next_we = 1'b0;
        n_key_wa  = IDX_W'(r_used);
        n_next_wa = IDX_W'(r_used);
        n_next_wd = NIL;
        n_raddr   = IDX_W'(r_cur);
        if (r_state == ST_START && r_job.op == OP_INSERT && r_used != NIL) begin
            n_key_we  = 1'b1;
            n_next_we = 1'b1;
        end else if (r_state == ST_STEP && r_job.op == OP_INSERT && w_rnext == NIL) begin
            // Tail reached: link the node just allocated (r_used already bumped).
            n_next_we = 1'b1;
            n_next_wa = IDX_W'(r_cur);
            n_next_wd = r_used - 1'b1;
        end
        if (r_state == ST_STEP) begin
            n_raddr = IDX_W'(w_rnext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_used   <= '0;
            r_oq_wp  <= 1'b0;
            r_oq_rp  <= 1'b0;
            r_oq_cnt <= 2'd0;
            for (int i = 0; i < BUCKETS; i++) begin
                r_head[i] <= NIL;
            end
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_job   <= i_job;
                        r_state <= ST_START;
                    end
                end
                ST_START: begin
                    r_res   <= '{status: (r_job.op == OP_INSERT) && (r_used == NIL),
                                 found: 1'b0, probes: '0};
                    r_steps <= '0;
                    r_cur   <= r_head[r_job.bucket];
                    if (r_job.op == OP_INSERT) begin
                        if (r_used == NIL) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_used <= r_used + 1'b1;
                            if (r_head[r_job.bucket] == NIL) begin
                                r_head[r_job.bucket] <= r_used;
                                r_state <= ST_DONE;
                            end else begin
                                r_state <= ST_WAIT;
                            end
                        end
                    end else if (r_head[r_job.bucket] == NIL) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    // Read of node r_cur is in flight.
                    r_state <= ST_STEP;
                end
                ST_STEP: begin
                    // w_rkey/w_rnext belong to r_cur; next read issued to w_rnext.
                    if (r_job.op == OP_FIND) begin
                        r_steps <= r_steps + 1'b1;
                        if (w_rkey == r_job.key) begin
                            r_res   <= '{status: 1'b0, found: 1'b1, probes: r_steps + 1'b1};
                            r_state <= ST_DONE;
                        end else if (w_rnext == NIL) begin
                            r_res   <= '{status: 1'b0, found: 1'b0, probes: r_steps + 1'b1};
                            r_state <= ST_DONE;
                        end
                    end else if (w_rnext == NIL) begin
                        r_state <= ST_DONE;
                    end
                    r_cur <= w_rnext;
                end
                ST_DONE: begin
                    if (w_enq) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (w_enq) begin
                r_oq[r_oq_wp] <= r_res;
                r_oq_wp <= ~r_oq_wp;
            end
            if (w_deq) begin
                r_oq_rp <= ~r_oq_rp;
            end
            r_oq_cnt <= r_oq_cnt + {1'b0, w_enq} - {1'b0, w_deq};
        end
    end

endmodule

/* rtl/core/chained_hash_table_top.sv */
// ----------------------------------------------------------------------------
// chained_hash_table_top
// Hash table with separate chaining over a bounded node pool.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Payload
//  input     in         push / full        i_op, i_key
//  result    out        empty / pop        o_status, o_found, o_probes
//  config    in         APB psel/penable   table_size at address 0
//
// The front reduces each key modulo the table size one key bit at a time
// and takes no new item until its job is queued. The back skips the walk
// on an empty chain, else walks up to 64 nodes; results wait for queue space.
// Front and back overlap through a two-entry queue; results wait in
// a two-entry queue of their own. Reset clears the bucket heads at once.
// ----------------------------------------------------------------------------
`include "chained_hash_table_top_defines.svh"

module chained_hash_table_top import cht_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic                i_op,
    input  logic [KEY_BITS-1:0] i_key,
    output logic                empty,
    input  logic                pop,
    output logic                o_status,
    output logic                o_found,
    output logic [PROBE_W-1:0]  o_probes,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam logic [1:0] ADDR_TABLE_SIZE = 2'd0;

    logic [SIZE_W-1:0] r_table_size;
    logic    w_job_valid, w_job_take;
    t_job    w_job;
    t_result w_result;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_TABLE_SIZE) ? {27'd0, r_table_size} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= TABLE_SIZE_RST;
        end else if (psel && penable && pwrite && paddr == ADDR_TABLE_SIZE) begin
            r_table_size <= pwdata[SIZE_W-1:0];
        end
    end

    cht_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_op        (i_op),
        .i_key       (i_key),
        .i_table_size(r_table_size),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_take  (w_job_take)
    );

    cht_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(w_job_valid),
        .i_job      (w_job),
        .o_job_take (w_job_take),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_result   (w_result)
    );

    assign o_status = w_result.status;
    assign o_found  = w_result.found;
    assign o_probes = w_result.probes;

    // An insert that fails on a full pool (status set) never reports found or probes.
    `CHT_ASSERT_IMPL(a_insert_quiet, i_clk, i_rst_n, !empty && o_status, !o_found && o_probes == '0, "status set on a result with find fields")
    // A found key always took at least one comparison.
    `CHT_ASSERT_IMPL(a_found_probes, i_clk, i_rst_n, !empty && o_found, o_probes != '0, "found with zero probes")
    // The front stays busy in the cycle after it takes an item.
    `CHT_ASSERT_NEXT(a_front_busy, i_clk, i_rst_n, push && !full, full, "front accepted back to back")

endmodule
